### rtl/ttsc_pkg.sv
// ----------------------------------------------------------------------------
// ttsc_pkg
// Shared types, constants and a helper function of the tree topology checker.
// ----------------------------------------------------------------------------
package ttsc_pkg;

   localparam int MAX_NODES_DEF = 256;
   localparam int MAX_TREES_DEF = 256;

   // Width of the root-seen epoch tags kept per tree id.
   localparam int EPOCH_W = 8;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NEG_TREE  = 3'd1,
      ST_ROOT_DEP  = 3'd2,
      ST_MULTI     = 3'd3,
      ST_PAR_RANGE = 3'd4,
      ST_TREE_MIS  = 3'd5,
      ST_DEP_MIS   = 3'd6,
      ST_CAPACITY  = 3'd7
   } status_type;

   // Address bits for a memory of the given depth, at least one.
   function automatic int addr_bits(input int depth);
      int bits;
      bits = $clog2(depth);
      return (bits < 1) ? 1 : bits;
   endfunction

endpackage

### rtl/tree_topology_stream_checker.sv
// ----------------------------------------------------------------------------
// tree_topology_stream_checker
// Checks a forest in parent-array form, one node per request, and answers
// each node with the sticky first error of the current topology.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  req_*     in         tdata: parent_index, node_depth, tree_number; tlast: last_node
//  rsp_*     out        tdata: status, node_number; tlast: final_res
//
//  One request per cycle sustained while rsp_tready is high and no clearing pass
//  runs; each passes the parent and root-tag memory reads, then the check and
//  write-back. After reset a clearing pass sweeps the root-tag memory while
//  req_tready stays low. The same pass runs again once every 255 topologies,
//  when the epoch counter wraps.
//  A stalled rsp_tready holds the result register and backs up into req_tready.
// ----------------------------------------------------------------------------
module tree_topology_stream_checker
   import ttsc_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF,
   parameter int MAX_TREES = MAX_TREES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // parent_index[15:0], node_depth[31:16], tree_number[47:32]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // status[2:0], node_number[10:3], zero fill[15:11]
   output logic        rsp_tlast
);

   localparam int NW     = addr_bits(MAX_NODES);
   localparam int TW     = addr_bits(MAX_TREES);
   localparam int CW     = $clog2(MAX_NODES + 1);
   localparam int NODE_W = 16 + TW;
   localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

   // Input fields.
   logic signed [15:0] req_par;
   logic signed [15:0] req_dep;
   logic signed [15:0] req_tree;
   assign req_par  = req_tdata[15:0];
   assign req_dep  = req_tdata[31:16];
   assign req_tree = req_tdata[47:32];

   // Control state.
   logic               accept;
   logic               s1_adv;
   logic               s1_valid_ff, s1_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]      counter_ff, counter_in;
   status_type         err_ff, err_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic               clr_ff, clr_in;
   logic [TW-1:0]      clr_addr_ff, clr_addr_in;
   logic               wrap_hold;

   // Stage 1 payload.
   logic signed [15:0] s1_par_ff, s1_dep_ff, s1_tree_ff;
   logic               s1_last_ff;
   logic [CW-1:0]      s1_idx_ff;

   // Forwarding of the write made by the item just ahead.
   logic               fwd_node_ff, fwd_node_in;
   logic [NW-1:0]      fwd_idx_ff;
   logic [15:0]        fwd_dep_ff;
   logic [TW-1:0]      fwd_tree_ff;
   logic               fwd_root_ff, fwd_root_in;
   logic [TW-1:0]      fwd_root_tree_ff;

   // Result register.
   status_type         rsp_status_ff;
   logic [7:0]         rsp_num_ff;
   logic               rsp_last_ff;

   // Memory ports.
   logic [NODE_W-1:0]  node_rd;
   logic               node_we;
   logic [EPOCH_W-1:0] tag_rd;
   logic               root_we;
   logic               tag_we;
   logic [TW-1:0]      tag_waddr;
   logic [EPOCH_W-1:0] tag_wdata;

   // Check logic.
   logic [15:0]        par_dep;
   logic [TW-1:0]      par_tree;
   logic               fwd_hit;
   logic               root_seen;
   status_type         chk;
   status_type         status_now;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   // Hold off new requests while a wrapping last node drains into a clearing pass.
   assign wrap_hold  = s1_valid_ff && s1_last_ff && (epoch_ff == EPOCH_MAX);
   assign req_tready = !clr_ff && !wrap_hold && (!s1_valid_ff || s1_adv);
   assign accept     = req_tvalid && req_tready;

   ttsc_ram #(
      .WIDTH (NODE_W),
      .DEPTH (MAX_NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (s1_idx_ff[NW-1:0]),
      .wr_data ({s1_tree_ff[TW-1:0], s1_dep_ff}),
      .rd_en   (accept),
      .rd_addr (req_par[NW-1:0]),
      .rd_data (node_rd)
   );

   ttsc_ram #(
      .WIDTH (EPOCH_W),
      .DEPTH (MAX_TREES)
   ) u_root_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (tag_waddr),
      .wr_data (tag_wdata),
      .rd_en   (accept),
      .rd_addr (req_tree[TW-1:0]),
      .rd_data (tag_rd)
   );

   always_comb begin
      fwd_hit   = fwd_node_ff && (fwd_idx_ff == s1_par_ff[NW-1:0]);
      par_dep   = fwd_hit ? fwd_dep_ff  : node_rd[15:0];
      par_tree  = fwd_hit ? fwd_tree_ff : node_rd[NODE_W-1:16];
      root_seen = (tag_rd == epoch_ff) ||
                  (fwd_root_ff && (fwd_root_tree_ff == s1_tree_ff[TW-1:0]));

      chk     = ST_OK;
      root_we = 1'b0;
      node_we = 1'b0;
      if (s1_tree_ff < 0) begin
         chk = ST_NEG_TREE;
      end else if ((17'(s1_idx_ff) >= 17'(MAX_NODES)) ||
                   ({1'b0, s1_tree_ff} >= 17'(MAX_TREES))) begin
         chk = ST_CAPACITY;
      end else if (s1_par_ff == -16'sd1) begin
         if (s1_dep_ff != 16'sd0) begin
            chk = ST_ROOT_DEP;
         end else if (root_seen) begin
            chk = ST_MULTI;
         end else begin
            root_we = 1'b1;
            node_we = 1'b1;
         end
      end else if ((s1_par_ff < 0) || ({1'b0, s1_par_ff} >= 17'(s1_idx_ff))) begin
         chk = ST_PAR_RANGE;
      end else if (par_tree != s1_tree_ff[TW-1:0]) begin
         chk = ST_TREE_MIS;
      end else if ((par_dep == 16'h7FFF) || (s1_dep_ff != (par_dep + 16'd1))) begin
         chk = ST_DEP_MIS;
      end else begin
         node_we = 1'b1;
      end

      // No new error is reported and nothing is stored once the topology has failed.
      if (err_ff != ST_OK) begin
         root_we = 1'b0;
         node_we = 1'b0;
      end
      root_we    = root_we && s1_adv;
      node_we    = node_we && s1_adv;
      status_now = (err_ff != ST_OK) ? err_ff : chk;

      tag_we    = clr_ff || root_we;
      tag_waddr = clr_ff ? clr_addr_ff : s1_tree_ff[TW-1:0];
      tag_wdata = clr_ff ? '0 : epoch_ff;
   end

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_adv ? 1'b1 : ((rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff);

      counter_in = counter_ff;
      if (accept) begin
         if (req_tlast) begin
            counter_in = '0;
         end else if (17'(counter_ff) < 17'(MAX_NODES)) begin
            counter_in = counter_ff + 1'b1;
         end
      end

      err_in      = err_ff;
      epoch_in    = epoch_ff;
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      fwd_node_in = fwd_node_ff;
      fwd_root_in = fwd_root_ff;
      if (s1_adv) begin
         err_in      = s1_last_ff ? ST_OK : status_now;
         fwd_node_in = node_we;
         fwd_root_in = root_we && !s1_last_ff;
         if (s1_last_ff) begin
            if (epoch_ff == EPOCH_MAX) begin
               epoch_in    = EPOCH_W'(1);
               clr_in      = 1'b1;
               clr_addr_in = '0;
            end else begin
               epoch_in = epoch_ff + 1'b1;
            end
         end
      end
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == TW'(MAX_TREES - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         counter_ff   <= '0;
         err_ff       <= ST_OK;
         epoch_ff     <= EPOCH_W'(1);
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         fwd_node_ff  <= 1'b0;
         fwd_root_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         counter_ff   <= counter_in;
         err_ff       <= err_in;
         epoch_ff     <= epoch_in;
         clr_ff       <= clr_in;
         clr_addr_ff  <= clr_addr_in;
         fwd_node_ff  <= fwd_node_in;
         fwd_root_ff  <= fwd_root_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_par_ff  <= req_par;
         s1_dep_ff  <= req_dep;
         s1_tree_ff <= req_tree;
         s1_last_ff <= req_tlast;
         s1_idx_ff  <= counter_ff;
      end
      if (s1_adv) begin
         fwd_idx_ff       <= s1_idx_ff[NW-1:0];
         fwd_dep_ff       <= s1_dep_ff;
         fwd_tree_ff      <= s1_tree_ff[TW-1:0];
         fwd_root_tree_ff <= s1_tree_ff[TW-1:0];
         rsp_status_ff    <= status_now;
         rsp_num_ff       <= 8'(s1_idx_ff);
         rsp_last_ff      <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_num_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

### rtl/ttsc_ram.sv
// ----------------------------------------------------------------------------
// ttsc_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ttsc_ram
   import ttsc_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [addr_bits(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]            wr_data,
   input  logic                        rd_en,
   input  logic [addr_bits(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
